// ===== rtl/core/wpcm_pkg.sv =====
`timescale 1ns / 1ps

package wpcm_pkg;

  // Command codes of an input request.
  localparam logic [2:0] CMD_SAMPLE  = 3'd0;
  localparam logic [2:0] CMD_START   = 3'd1;
  localparam logic [2:0] CMD_CAPTURE = 3'd2;
  localparam logic [2:0] CMD_CANCEL  = 3'd3;
  localparam logic [2:0] CMD_CLEAR   = 3'd4;

  // Slots of the bounds arrays.
  localparam int B_WMIN = 0;
  localparam int B_WCTR = 1;
  localparam int B_WMAX = 2;
  localparam int B_AMIN = 3;
  localparam int B_AMAX = 4;
  localparam int B_BMIN = 5;
  localparam int B_BMAX = 6;
  localparam int NUM_BOUNDS = 7;

  // Mapped value limits.
  localparam logic signed [16:0] WHEEL_NEG_LIM = -17'sd128;
  localparam logic signed [16:0] WHEEL_POS_LIM = 17'sd127;
  localparam logic signed [16:0] PEDAL_LIM     = 17'sd255;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_WHEEL  = 3'd1,
    ST_CENTER = 3'd2,
    ST_ACCEL  = 3'd3,
    ST_BRAKE  = 3'd4
  } step_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_FIN,
    S_PUSH
  } state_e;

  typedef enum logic [1:0] {
    AX_WHEEL,
    AX_ACCEL,
    AX_BRAKE
  } axis_e;

endpackage

// ===== rtl/core/wpcm_in_if.sv =====
`timescale 1ns / 1ps

interface wpcm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] wheel_sample;
  logic [15:0] accel_sample;
  logic [15:0] brake_sample;

  modport source (
    output valid, command, wheel_sample, accel_sample, brake_sample,
    input  ready
  );
  modport sink (
    input  valid, command, wheel_sample, accel_sample, brake_sample,
    output ready
  );
endinterface

// ===== rtl/core/wpcm_out_if.sv =====
`timescale 1ns / 1ps

interface wpcm_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] wheel_value;
  logic [15:0]        accel_value;
  logic [15:0]        brake_value;
  logic               raw_mode;
  logic               calib_valid;
  logic [2:0]         wizard_step;
  logic               committed;

  modport source (
    output valid, wheel_value, accel_value, brake_value, raw_mode, calib_valid,
           wizard_step, committed,
    input  ready
  );
  modport sink (
    input  valid, wheel_value, accel_value, brake_value, raw_mode, calib_valid,
           wizard_step, committed,
    output ready
  );
endinterface

// ===== rtl/core/wpcm_cfg_if.sv =====
`timescale 1ns / 1ps

interface wpcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

// ===== rtl/core/wheel_pedal_calibration_mapper.sv =====
`timescale 1ns / 1ps

// Steering wheel and pedal calibration mapper. Each request is a sample or a
// wizard command (start, capture, cancel, clear) and yields one result. A
// command, or a sample taken while the wizard runs, is set in the pending
// result registers when accepted and moved to the output register once that
// is empty or being read. A sample mapped outside the wizard runs its three
// axes one after the other through a single bit-serial restoring divider that
// retires one quotient bit per cycle; a pedal that clamps or uses the legacy
// pedal shift skips the divider. One request is in flight at a time; a
// finished result waits in the output register while the next request is taken.
module wheel_pedal_calibration_mapper #(
  parameter int RAW_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  wpcm_in_if.sink    sample_i,
  wpcm_out_if.source result_o,
  wpcm_cfg_if.sink   cfg_i
);

  localparam int W  = RAW_WIDTH;
  localparam int NW = W + 8;
  localparam int CW = $clog2(NW);
  localparam logic [W-1:0] HALF = W'(1) << (W - 1);

  // Configuration.
  logic [15:0] raw_mask_q;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_mask_q <= 16'hFFFF;
    end else if (cfg_i.valid && cfg_i.ready) begin
      raw_mask_q <= cfg_i.data;
    end
  end

  wpcm_pkg::state_e state_q, state_d;
  wpcm_pkg::axis_e  axis_q, axis_d;

  logic accept;
  assign sample_i.ready = (state_q == wpcm_pkg::S_IDLE);
  assign accept = sample_i.valid && sample_i.ready;

  logic [W-1:0] w_in, a_in, b_in;
  assign w_in = sample_i.wheel_sample[W-1:0] & raw_mask_q[W-1:0];
  assign a_in = sample_i.accel_sample[W-1:0] & raw_mask_q[W-1:0];
  assign b_in = sample_i.brake_sample[W-1:0] & raw_mask_q[W-1:0];

  // Wizard and calibration state.
  wpcm_pkg::step_e step_q, step_d;
  logic            act_valid_q, act_valid_d;
  logic [W-1:0]    work_q [wpcm_pkg::NUM_BOUNDS];
  logic [W-1:0]    work_d [wpcm_pkg::NUM_BOUNDS];
  logic [W-1:0]    act_q  [wpcm_pkg::NUM_BOUNDS];
  logic [W-1:0]    act_d  [wpcm_pkg::NUM_BOUNDS];
  logic [W-1:0]    last_q, last_d;
  logic            commit;
  logic            work_ordered;

  assign work_ordered = (work_q[wpcm_pkg::B_WMIN] < work_q[wpcm_pkg::B_WCTR])
                     && (work_q[wpcm_pkg::B_WCTR] < work_q[wpcm_pkg::B_WMAX])
                     && (work_q[wpcm_pkg::B_AMIN] < work_q[wpcm_pkg::B_AMAX])
                     && (work_q[wpcm_pkg::B_BMIN] < work_q[wpcm_pkg::B_BMAX]);

  always_comb begin
    step_d      = step_q;
    act_valid_d = act_valid_q;
    work_d      = work_q;
    act_d       = act_q;
    last_d      = last_q;
    commit      = 1'b0;
    unique case (sample_i.command)
      wpcm_pkg::CMD_SAMPLE: begin
        if (step_q != wpcm_pkg::ST_IDLE) begin
          last_d = w_in;
          unique case (step_q)
            wpcm_pkg::ST_WHEEL: begin
              if (w_in < work_q[wpcm_pkg::B_WMIN]) work_d[wpcm_pkg::B_WMIN] = w_in;
              if (w_in > work_q[wpcm_pkg::B_WMAX]) work_d[wpcm_pkg::B_WMAX] = w_in;
            end
            wpcm_pkg::ST_ACCEL: begin
              if (a_in < work_q[wpcm_pkg::B_AMIN]) work_d[wpcm_pkg::B_AMIN] = a_in;
              if (a_in > work_q[wpcm_pkg::B_AMAX]) work_d[wpcm_pkg::B_AMAX] = a_in;
            end
            wpcm_pkg::ST_BRAKE: begin
              if (b_in < work_q[wpcm_pkg::B_BMIN]) work_d[wpcm_pkg::B_BMIN] = b_in;
              if (b_in > work_q[wpcm_pkg::B_BMAX]) work_d[wpcm_pkg::B_BMAX] = b_in;
            end
            default: ;
          endcase
        end
      end
      wpcm_pkg::CMD_START: begin
        work_d[wpcm_pkg::B_WMIN] = '1;
        work_d[wpcm_pkg::B_WCTR] = '0;
        work_d[wpcm_pkg::B_WMAX] = '0;
        work_d[wpcm_pkg::B_AMIN] = '1;
        work_d[wpcm_pkg::B_AMAX] = '0;
        work_d[wpcm_pkg::B_BMIN] = '1;
        work_d[wpcm_pkg::B_BMAX] = '0;
        last_d = '0;
        step_d = wpcm_pkg::ST_WHEEL;
      end
      wpcm_pkg::CMD_CAPTURE: begin
        unique case (step_q)
          wpcm_pkg::ST_WHEEL:  step_d = wpcm_pkg::ST_CENTER;
          wpcm_pkg::ST_CENTER: begin
            work_d[wpcm_pkg::B_WCTR] = last_q;
            step_d = wpcm_pkg::ST_ACCEL;
          end
          wpcm_pkg::ST_ACCEL:  step_d = wpcm_pkg::ST_BRAKE;
          wpcm_pkg::ST_BRAKE: begin
            // A commit with unordered ranges still ends the wizard.
            if (work_ordered) begin
              act_d       = work_q;
              act_valid_d = 1'b1;
            end
            step_d = wpcm_pkg::ST_IDLE;
            commit = 1'b1;
          end
          default: ;
        endcase
      end
      wpcm_pkg::CMD_CANCEL: step_d = wpcm_pkg::ST_IDLE;
      wpcm_pkg::CMD_CLEAR: begin
        for (int i = 0; i < wpcm_pkg::NUM_BOUNDS; i++) act_d[i] = '0;
        act_valid_d = 1'b0;
        step_d      = wpcm_pkg::ST_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= wpcm_pkg::ST_IDLE;
      act_valid_q <= 1'b0;
      last_q      <= '0;
      for (int i = 0; i < wpcm_pkg::NUM_BOUNDS; i++) begin
        act_q[i] <= '0;
      end
      work_q[wpcm_pkg::B_WMIN] <= '1;
      work_q[wpcm_pkg::B_WCTR] <= '0;
      work_q[wpcm_pkg::B_WMAX] <= '0;
      work_q[wpcm_pkg::B_AMIN] <= '1;
      work_q[wpcm_pkg::B_AMAX] <= '0;
      work_q[wpcm_pkg::B_BMIN] <= '1;
      work_q[wpcm_pkg::B_BMAX] <= '0;
    end else if (accept) begin
      step_q      <= step_d;
      act_valid_q <= act_valid_d;
      last_q      <= last_d;
      work_q      <= work_d;
      act_q       <= act_d;
    end
  end

  // Latched masked sample for the mapping pass.
  logic [W-1:0] smp_q [3];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q[0] <= w_in;
      smp_q[1] <= a_in;
      smp_q[2] <= b_in;
    end
  end

  // Per-axis setup: either a fixed value or a numerator and divisor.
  logic               su_fixed;
  logic signed [16:0] su_val;
  logic [NW-1:0]      su_num;
  logic [W-1:0]       su_den;
  logic               su_neg;
  logic [W-1:0]       r, lo, hi, diff;

  always_comb begin
    su_fixed = 1'b0;
    su_val   = '0;
    su_num   = '0;
    su_den   = '0;
    su_neg   = 1'b0;
    diff     = '0;
    r        = smp_q[0];
    lo       = act_q[wpcm_pkg::B_WMIN];
    hi       = act_q[wpcm_pkg::B_WMAX];
    unique case (axis_q)
      wpcm_pkg::AX_WHEEL: begin
        if (act_valid_q) begin
          if (r <= act_q[wpcm_pkg::B_WCTR]) begin
            diff   = act_q[wpcm_pkg::B_WCTR] - r;
            su_den = act_q[wpcm_pkg::B_WCTR] - lo;
            su_num = NW'({diff, 7'b0});
            su_neg = 1'b1;
            su_val = wpcm_pkg::WHEEL_NEG_LIM;
          end else begin
            diff   = r - act_q[wpcm_pkg::B_WCTR];
            su_den = hi - act_q[wpcm_pkg::B_WCTR];
            su_num = NW'({diff, 7'b0}) - NW'(diff);
            su_val = wpcm_pkg::WHEEL_POS_LIM;
          end
          su_fixed = (su_den == '0);
        end else begin
          // Legacy scaling: (r - half) * 127 / half.
          if (r >= HALF) begin
            diff = r - HALF;
          end else begin
            diff   = HALF - r;
            su_neg = 1'b1;
          end
          su_den = HALF;
          su_num = NW'({diff, 7'b0}) - NW'(diff);
        end
      end
      wpcm_pkg::AX_ACCEL, wpcm_pkg::AX_BRAKE: begin
        if (axis_q == wpcm_pkg::AX_ACCEL) begin
          r  = smp_q[1];
          lo = act_q[wpcm_pkg::B_AMIN];
          hi = act_q[wpcm_pkg::B_AMAX];
        end else begin
          r  = smp_q[2];
          lo = act_q[wpcm_pkg::B_BMIN];
          hi = act_q[wpcm_pkg::B_BMAX];
        end
        if (!act_valid_q || hi <= lo) begin
          su_fixed = 1'b1;
          su_val   = 17'(r >> (W - 8));
        end else if (r <= lo) begin
          su_fixed = 1'b1;
          su_val   = '0;
        end else if (r >= hi) begin
          su_fixed = 1'b1;
          su_val   = wpcm_pkg::PEDAL_LIM;
        end else begin
          diff   = r - lo;
          su_den = hi - lo;
          su_num = NW'({diff, 8'b0}) - NW'(diff);
        end
      end
      default: ;
    endcase
  end

  // Bit-serial restoring divider: one quotient bit per cycle.
  logic [NW-1:0] quo_q;
  logic [W-1:0]  rem_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q;
  logic [W:0]    rem_sh;
  logic          ge;

  assign rem_sh = {rem_q, quo_q[NW-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (state_q == wpcm_pkg::S_SETUP) begin
      quo_q <= su_num;
      rem_q <= '0;
      den_q <= su_den;
      neg_q <= su_neg;
      cnt_q <= CW'(NW - 1);
    end else if (state_q == wpcm_pkg::S_DIV) begin
      quo_q <= {quo_q[NW-2:0], ge};
      rem_q <= ge ? W'(rem_sh - {1'b0, den_q}) : rem_sh[W-1:0];
      cnt_q <= cnt_q - CW'(1);
    end
  end

  // Sign and clamp of the quotient.
  logic signed [16:0] fin_val;

  always_comb begin
    if (neg_q) begin
      fin_val = (quo_q > NW'(128)) ? wpcm_pkg::WHEEL_NEG_LIM : -$signed(17'(quo_q));
    end else if (axis_q == wpcm_pkg::AX_WHEEL) begin
      fin_val = (quo_q > NW'(127)) ? wpcm_pkg::WHEEL_POS_LIM : $signed(17'(quo_q));
    end else begin
      fin_val = (quo_q > NW'(255)) ? wpcm_pkg::PEDAL_LIM : $signed(17'(quo_q));
    end
  end

  // Pending result.
  logic signed [16:0] res_wheel_q;
  logic [15:0]        res_accel_q, res_brake_q;
  logic               res_raw_q, res_cal_q, res_commit_q;
  logic [2:0]         res_step_q;
  logic               ax_wr;
  logic signed [16:0] ax_val;

  assign ax_wr  = ((state_q == wpcm_pkg::S_SETUP) && su_fixed) || (state_q == wpcm_pkg::S_FIN);
  assign ax_val = (state_q == wpcm_pkg::S_FIN) ? fin_val : su_val;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_raw_q    <= (step_d != wpcm_pkg::ST_IDLE);
      res_cal_q    <= act_valid_d;
      res_step_q   <= step_d;
      res_commit_q <= commit;
      if (sample_i.command == wpcm_pkg::CMD_SAMPLE) begin
        res_wheel_q <= $signed(17'(w_in));
        res_accel_q <= 16'(a_in);
        res_brake_q <= 16'(b_in);
      end else begin
        res_wheel_q <= '0;
        res_accel_q <= '0;
        res_brake_q <= '0;
      end
    end else if (ax_wr) begin
      unique case (axis_q)
        wpcm_pkg::AX_WHEEL: res_wheel_q <= ax_val;
        wpcm_pkg::AX_ACCEL: res_accel_q <= ax_val[15:0];
        wpcm_pkg::AX_BRAKE: res_brake_q <= ax_val[15:0];
        default: ;
      endcase
    end
  end

  // Output register.
  logic out_valid_q;
  logic out_load;

  assign out_load = (state_q == wpcm_pkg::S_PUSH) && (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      result_o.wheel_value <= res_wheel_q;
      result_o.accel_value <= res_accel_q;
      result_o.brake_value <= res_brake_q;
      result_o.raw_mode    <= res_raw_q;
      result_o.calib_valid <= res_cal_q;
      result_o.wizard_step <= res_step_q;
      result_o.committed   <= res_commit_q;
    end
  end

  assign result_o.valid = out_valid_q;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wpcm_pkg::S_IDLE;
      axis_q  <= wpcm_pkg::AX_WHEEL;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    unique case (state_q)
      wpcm_pkg::S_IDLE: begin
        if (accept) begin
          axis_d = wpcm_pkg::AX_WHEEL;
          if (sample_i.command == wpcm_pkg::CMD_SAMPLE && step_q == wpcm_pkg::ST_IDLE) begin
            state_d = wpcm_pkg::S_SETUP;
          end else begin
            state_d = wpcm_pkg::S_PUSH;
          end
        end
      end
      wpcm_pkg::S_SETUP: begin
        if (!su_fixed) begin
          state_d = wpcm_pkg::S_DIV;
        end else if (axis_q == wpcm_pkg::AX_BRAKE) begin
          state_d = wpcm_pkg::S_PUSH;
        end else begin
          axis_d = (axis_q == wpcm_pkg::AX_WHEEL) ? wpcm_pkg::AX_ACCEL : wpcm_pkg::AX_BRAKE;
        end
      end
      wpcm_pkg::S_DIV: begin
        if (cnt_q == '0) state_d = wpcm_pkg::S_FIN;
      end
      wpcm_pkg::S_FIN: begin
        if (axis_q == wpcm_pkg::AX_BRAKE) begin
          state_d = wpcm_pkg::S_PUSH;
        end else begin
          state_d = wpcm_pkg::S_SETUP;
          axis_d  = (axis_q == wpcm_pkg::AX_WHEEL) ? wpcm_pkg::AX_ACCEL : wpcm_pkg::AX_BRAKE;
        end
      end
      wpcm_pkg::S_PUSH: begin
        if (out_load) state_d = wpcm_pkg::S_IDLE;
      end
      default: state_d = wpcm_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // Only one request is in flight.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i.valid && sample_i.ready |=> !sample_i.ready)
    else $error("request accepted while another was in flight");

  a_raw_matches_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |->
      (result_o.raw_mode == (result_o.wizard_step != wpcm_pkg::ST_IDLE)))
    else $error("raw_mode disagrees with wizard_step");

  a_commit_ends_wizard: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.committed |-> !result_o.raw_mode)
    else $error("commit left the wizard running");

  a_wheel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.raw_mode |->
      (result_o.wheel_value >= wpcm_pkg::WHEEL_NEG_LIM) &&
      (result_o.wheel_value <= wpcm_pkg::WHEEL_POS_LIM))
    else $error("mapped wheel value out of range");

  a_pedal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && !result_o.raw_mode |->
      (result_o.accel_value <= 16'd255) && (result_o.brake_value <= 16'd255))
    else $error("mapped pedal value out of range");
`endif

endmodule
